[sv/rtc2unix_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rtc2unix_pkg;

  // Pipeline depth from transfer in to result strobe
  localparam int unsigned Latency = 4;

  // Seconds from 1970-01-01 to 2000-01-01
  localparam logic [31:0] Epoch2000 = 32'd946684800;
  localparam logic [16:0] SecPerDay = 17'd86400;
  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [5:0]  SecPerMin = 6'd60;
  localparam logic [8:0]  DaysPerYear = 9'd365;

  // Raw register snapshot
  typedef struct packed {
    logic [7:0] sec_reg;
    logic [7:0] min_reg;
    logic [7:0] hour_reg;
    logic [7:0] date_reg;
    logic [7:0] month_reg;
    logic [7:0] weekday_reg;
    logic [7:0] year_reg;
  } rtc_in_t;

  // Converted result
  typedef struct packed {
    logic [31:0] unix_seconds;
    logic [6:0]  second_out;
    logic [6:0]  minute_out;
    logic [5:0]  hour_out;
    logic [5:0]  day_out;
    logic [4:0]  month_out;
    logic [2:0]  weekday_out;
    logic [7:0]  year_out;
    logic        clock_halted;
    logic        range_error;
  } rtc_out_t;

  // Decoded fields carried down the pipeline
  typedef struct packed {
    logic [6:0] second;
    logic [6:0] minute;
    logic [5:0] hour;
    logic [5:0] day;
    logic [4:0] month;
    logic [2:0] weekday;
    logic [7:0] year;
    logic       halted;
    logic       err;
  } dec_t;

  // Tens digit * 10 + units digit; nibbles above 9 are not checked
  function automatic logic [7:0] bcd2bin(input logic [7:0] v);
    logic [7:0] tens;
    logic [7:0] units;
    tens  = {4'd0, v[7:4]};
    units = {4'd0, v[3:0]};
    return 8'((tens << 3) + (tens << 1) + units);
  endfunction

  // Days in the year before the first of the given month (non-leap)
  function automatic logic [8:0] days_before(input logic [4:0] month);
    logic [8:0] d;
    unique case (month)
      5'd1:    d = 9'd0;
      5'd2:    d = 9'd31;
      5'd3:    d = 9'd59;
      5'd4:    d = 9'd90;
      5'd5:    d = 9'd120;
      5'd6:    d = 9'd151;
      5'd7:    d = 9'd181;
      5'd8:    d = 9'd212;
      5'd9:    d = 9'd243;
      5'd10:   d = 9'd273;
      5'd11:   d = 9'd304;
      5'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[sv/rtc2unix_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtc2unix_decode import rtc2unix_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  input  wire rtc_in_t req_i,
  output logic         valid_o,
  output dec_t         dec_o
);

  logic       valid_q;
  dec_t       dec_d, dec_q;
  logic [7:0] hr12;
  logic [5:0] hr12_fix;

  always_comb begin
    hr12     = bcd2bin({3'd0, req_i.hour_reg[4:0]});
    // 12 AM is hour 0, 12 PM is hour 12
    hr12_fix = (hr12 == 8'd12) ? 6'd0 : 6'(hr12);

    dec_d.second  = 7'(bcd2bin({1'b0, req_i.sec_reg[6:0]}));
    dec_d.minute  = 7'(bcd2bin({1'b0, req_i.min_reg[6:0]}));
    dec_d.day     = 6'(bcd2bin({2'd0, req_i.date_reg[5:0]}));
    dec_d.month   = 5'(bcd2bin({3'd0, req_i.month_reg[4:0]}));
    dec_d.weekday = req_i.weekday_reg[2:0];
    dec_d.year    = bcd2bin(req_i.year_reg);
    dec_d.halted  = req_i.sec_reg[7];
    if (req_i.hour_reg[7]) begin
      dec_d.hour = hr12_fix + (req_i.hour_reg[5] ? 6'd12 : 6'd0);
    end else begin
      dec_d.hour = 6'(bcd2bin({2'd0, req_i.hour_reg[5:0]}));
    end
    dec_d.err = (dec_d.month == 5'd0) || (dec_d.month > 5'd12) ||
                (dec_d.day == 6'd0) || (dec_d.year > 8'd99);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

[sv/rtc2unix_days.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtc2unix_days import rtc2unix_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire dec_t        dec_i,
  output logic             valid_o,
  output dec_t             dec_o,
  output logic [15:0]      days_o,
  output logic [17:0]      tod_o
);

  logic        valid_q;
  dec_t        dec_q;
  logic [15:0] days_d, days_q;
  logic [17:0] tod_d, tod_q;
  logic [15:0] leap_days;
  logic        leap_adj;

  always_comb begin
    // every fourth year from 2000 is a leap year
    leap_days = 16'(({1'b0, dec_i.year} + 9'd3) >> 2);
    leap_adj  = (dec_i.year[1:0] == 2'd0) && (dec_i.month > 5'd2);
    days_d    = 16'(16'(dec_i.year) * 16'(DaysPerYear)) + leap_days
              + 16'(days_before(dec_i.month)) + 16'(leap_adj)
              + 16'(dec_i.day) - 16'd1;
    tod_d     = 18'(18'(dec_i.hour) * 18'(SecPerHour))
              + 18'(18'(dec_i.minute) * 18'(SecPerMin))
              + 18'(dec_i.second);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dec_q  <= dec_i;
      days_q <= days_d;
      tod_q  <= tod_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;
  assign days_o  = days_q;
  assign tod_o   = tod_q;

endmodule

`default_nettype wire

[sv/rtc2unix_assemble.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtc2unix_assemble import rtc2unix_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire dec_t        dec_i,
  input  wire logic [15:0] days_i,
  input  wire logic [17:0] tod_i,
  output logic             done_o,
  output rtc_out_t         res_o
);

  // stage A: day scaling, offset folded into time of day
  logic        va_q;
  dec_t        dec_a_q;
  logic [31:0] day_secs_d, day_secs_q;
  logic [31:0] base_d, base_q;
  // stage B: final sum
  logic        vb_q;
  rtc_out_t    res_d, res_q;

  always_comb begin
    day_secs_d = 32'(32'(days_i) * 32'(SecPerDay));
    base_d     = 32'(tod_i) + Epoch2000;
  end

  always_comb begin
    res_d.unix_seconds = dec_a_q.err ? 32'd0 : day_secs_q + base_q;
    res_d.second_out   = dec_a_q.second;
    res_d.minute_out   = dec_a_q.minute;
    res_d.hour_out     = dec_a_q.hour;
    res_d.day_out      = dec_a_q.day;
    res_d.month_out    = dec_a_q.month;
    res_d.weekday_out  = dec_a_q.weekday;
    res_d.year_out     = dec_a_q.year;
    res_d.clock_halted = dec_a_q.halted;
    res_d.range_error  = dec_a_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dec_a_q    <= dec_i;
      day_secs_q <= day_secs_d;
      base_q     <= base_d;
    end
    if (va_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = vb_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

[sv/rtc_bcd_registers_to_unix_time.sv]
`timescale 1ns / 1ps
`default_nettype none

// BCD clock snapshot to Unix seconds. Present the seven raw clock-register
// bytes on req_i with start_i high for one cycle; busy_o never rises, so a
// new snapshot may be transferred on every clock cycle. Each snapshot gives
// exactly one result, on res_o with done_o high for a single cycle, after
// the decode, day count, day scaling and final sum registers, in order.
// The result is not held: the receiver must take it in that cycle.
// Fields are decoded as tens * 10 + units with no digit check. The hour is
// read in 12-hour form when bit 7 of the hour byte is set (12 AM gives 0,
// 12 PM gives 12). A month outside 1..12, a day of 0 or a year above 99
// sets range_error and forces unix_seconds to 0; decoded fields still show.
// Out-of-range hours, minutes, seconds and days simply add in, wrapping
// modulo 2^32.

module rtc_bcd_registers_to_unix_time import rtc2unix_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  output logic         busy_o,
  input  wire rtc_in_t req_i,
  output logic         done_o,
  output rtc_out_t     res_o
);

  logic        accept;
  logic        v1, v2;
  dec_t        dec1, dec2;
  logic [15:0] days2;
  logic [17:0] tod2;

  // fully pipelined, nothing ever holds the input off
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage 1: mask and BCD decode, range check
  rtc2unix_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .req_i   (req_i),
    .valid_o (v1),
    .dec_o   (dec1)
  );

  // stage 2: days since 2000-01-01 and seconds into the day
  rtc2unix_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .dec_i   (dec1),
    .valid_o (v2),
    .dec_o   (dec2),
    .days_o  (days2),
    .tod_o   (tod2)
  );

  // stages 3 and 4: days * 86400, then the final sum and error forcing
  rtc2unix_assemble u_assemble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .dec_i   (dec2),
    .days_i  (days2),
    .tod_i   (tod2),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

[sv/rtc2unix_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtc2unix_checker import rtc2unix_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start_i,
  input wire logic     busy_o,
  input wire rtc_in_t  req_i,
  input wire logic     done_o,
  input wire rtc_out_t res_o
);

  // input side never stalls
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  // every result strobe follows a transfer by the pipeline depth
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without matching transfer");

  a_weekday_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.weekday_out == $past(req_i.weekday_reg[2:0], Latency))
    else $error("weekday not carried with its item");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.range_error |-> res_o.unix_seconds == 32'd0)
    else $error("timestamp not forced to zero on range error");

  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.range_error |->
      res_o.month_out != 5'd0 && res_o.month_out <= 5'd12 &&
      res_o.day_out != 6'd0 && res_o.year_out <= 8'd99)
    else $error("range error missed");

endmodule

bind rtc_bcd_registers_to_unix_time rtc2unix_checker u_rtc2unix_checker (.*);

`default_nettype wire

[tb/rtc_bcd_registers_to_unix_time_tb.sv]
`timescale 1ns / 1ps

// Snapshot-to-epoch converter bench. Seven raw clock bytes go in per transfer.
// Exactly one result comes back per transfer, in order, and the receiver cannot
// hold it off. Every accepted snapshot queues its expected result. Each result
// strobe is checked field by field against the oldest queued entry.

module rtc_bcd_registers_to_unix_time_tb;
  import rtc2unix_pkg::*;

  localparam int unsigned RandomItems = 1800;
  localparam int unsigned QuietTail   = 300;     // last items sent back to back
  localparam int unsigned CycleLimit  = 200000;

  // Field masks of the raw register bytes
  localparam logic [7:0] HaltBit   = 8'h80;
  localparam logic [7:0] TwelveBit = 8'h80;
  localparam logic [7:0] PmBit     = 8'h20;
  localparam logic [7:0] SpareHour = 8'h40;  // ignored in both hour modes
  localparam logic [7:0] SpareDate = 8'hC0;
  localparam logic [7:0] SpareMon  = 8'hE0;

  localparam logic [31:0] SecsTo2000 = 32'd946684800;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  rtc_in_t  req_i;
  logic     done_o;
  rtc_out_t res_o;

  rtc_bcd_registers_to_unix_time u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic [31:0] decode_bcd(input logic [7:0] v);
    return 32'(v[7:4]) * 32'd10 + 32'(v[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(input int v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // non-leap month lengths
  function automatic int month_days(input int m);
    case (m)
      2:       return 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic rtc_out_t predict_conversion(input rtc_in_t s);
    rtc_out_t    r;
    logic [31:0] sec, min, hour, day, month, year, days, stamp;
    logic        bad;
    int          m;
    sec   = decode_bcd(s.sec_reg & 8'h7F);
    min   = decode_bcd(s.min_reg & 8'h7F);
    day   = decode_bcd(s.date_reg & 8'h3F);
    month = decode_bcd(s.month_reg & 8'h1F);
    year  = decode_bcd(s.year_reg);
    // 12-hour form: 12 folds to 0 before PM adds 12 (midnight 0, noon 12)
    if ((s.hour_reg & TwelveBit) != 8'h00) begin
      hour = decode_bcd(s.hour_reg & 8'h1F);
      if (hour == 32'd12) hour = 32'd0;
      if ((s.hour_reg & PmBit) != 8'h00) hour = hour + 32'd12;
    end else begin
      hour = decode_bcd(s.hour_reg & 8'h3F);
    end
    bad   = (month < 32'd1) || (month > 32'd12) || (day == 32'd0) || (year > 32'd99);
    stamp = 32'd0;
    if (!bad) begin
      days = year * 32'd365 + (year + 32'd3) / 32'd4;
      for (m = 1; m < int'(month); m++) days = days + 32'(month_days(m));
      if (month > 32'd2 && year[1:0] == 2'b00) days = days + 32'd1;
      days  = days + day - 32'd1;
      // out-of-range fields simply add in; 32-bit sum wraps
      stamp = days * 32'd86400 + hour * 32'd3600 + min * 32'd60 + sec + SecsTo2000;
    end
    r.unix_seconds = stamp;
    r.second_out   = sec[6:0];
    r.minute_out   = min[6:0];
    r.hour_out     = hour[5:0];
    r.day_out      = day[5:0];
    r.month_out    = month[4:0];
    r.weekday_out  = s.weekday_reg[2:0];
    r.year_out     = year[7:0];
    r.clock_halted = s.sec_reg[7];
    r.range_error  = bad;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  function automatic rtc_in_t make_snap(input logic [7:0] sec, input logic [7:0] min,
                                        input logic [7:0] hour, input logic [7:0] date,
                                        input logic [7:0] month, input logic [7:0] wday,
                                        input logic [7:0] year);
    rtc_in_t s;
    s.sec_reg     = sec;
    s.min_reg     = min;
    s.hour_reg    = hour;
    s.date_reg    = date;
    s.month_reg   = month;
    s.weekday_reg = wday;
    s.year_reg    = year;
    return s;
  endfunction

  function automatic rtc_out_t make_result(input logic [31:0] stamp, input int sec,
                                           input int min, input int hour, input int day,
                                           input int month, input int wday, input int year,
                                           input logic halted, input logic bad);
    rtc_out_t r;
    r.unix_seconds = stamp;
    r.second_out   = 7'(sec);
    r.minute_out   = 7'(min);
    r.hour_out     = 6'(hour);
    r.day_out      = 6'(day);
    r.month_out    = 5'(month);
    r.weekday_out  = 3'(wday);
    r.year_out     = 8'(year);
    r.clock_halted = halted;
    r.range_error  = bad;
    return r;
  endfunction

  // Mostly sane calendar snapshots with random spare bits, some with one field
  // broken, the rest raw noise.
  function automatic rtc_in_t random_snapshot();
    rtc_in_t s;
    int      kind, yr, mon, dy, len;
    s.sec_reg     = 8'($urandom);
    s.min_reg     = 8'($urandom);
    s.hour_reg    = 8'($urandom);
    s.date_reg    = 8'($urandom);
    s.month_reg   = 8'($urandom);
    s.weekday_reg = 8'($urandom);
    s.year_reg    = 8'($urandom);
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      yr  = $urandom_range(0, 99);
      mon = $urandom_range(1, 12);
      len = month_days(mon) + ((mon == 2 && yr % 4 == 0) ? 1 : 0);
      dy  = ($urandom_range(0, 7) == 0) ? len : $urandom_range(1, len);
      s.sec_reg   = (s.sec_reg & HaltBit) | to_bcd($urandom_range(0, 59));
      s.min_reg   = (s.min_reg & 8'h80) | to_bcd($urandom_range(0, 59));
      if ($urandom_range(0, 1) == 1) begin
        s.hour_reg = TwelveBit | (s.hour_reg & (SpareHour | PmBit))
                   | to_bcd($urandom_range(1, 12));
      end else begin
        s.hour_reg = (s.hour_reg & SpareHour) | to_bcd($urandom_range(0, 23));
      end
      s.date_reg  = (s.date_reg & SpareDate) | to_bcd(dy);
      s.month_reg = (s.month_reg & SpareMon) | to_bcd(mon);
      s.year_reg  = to_bcd(yr);
      if (kind == 7) begin
        case ($urandom_range(0, 3))
          0: s.date_reg  = s.date_reg & SpareDate;
          1: s.month_reg = (s.month_reg & SpareMon)
                         | (($urandom_range(0, 3) == 0) ? 8'h00 : 8'h13 + 8'($urandom_range(0, 12)));
          2: s.year_reg  = 8'h9A + 8'($urandom_range(0, 101));
          default: begin
            // time fields past their normal range: no error, they just add in
            s.hour_reg = (s.hour_reg & SpareHour) | to_bcd($urandom_range(24, 39));
            s.min_reg  = (s.min_reg & 8'h80) | to_bcd($urandom_range(60, 79));
          end
        endcase
      end
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: rows with a typed-in result are trivially read off;
  // the rest go through the predictor.
  // --------------------------------------------------------------------------

  typedef struct packed {
    rtc_in_t  snap;
    logic     has_fixed;
    rtc_out_t fixed_res;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic add_row(input rtc_in_t snap, input logic has_fixed, input rtc_out_t res);
    directed_row_t row;
    row.snap      = snap;
    row.has_fixed = has_fixed;
    row.fixed_res = res;
    directed_rows.push_back(row);
  endtask

  initial begin
    // all zero: month 0 and day 0, range error
    add_row(make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            make_result(32'd0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    // all ones: widest decodes, 12-hour PM of hour 25, range error
    add_row(make_snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
            make_result(32'd0, 85, 85, 37, 45, 25, 7, 165, 1'b1, 1'b1));
    // 2000-01-01 00:00:00, the start of the count
    add_row(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h06, 8'h00), 1'b1,
            make_result(SecsTo2000, 0, 0, 0, 1, 1, 6, 0, 1'b0, 1'b0));
    // month 13
    add_row(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00, 8'h00), 1'b1,
            make_result(32'd0, 0, 0, 0, 1, 13, 0, 0, 1'b0, 1'b1));
    // day 0 in a valid month
    add_row(make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00), 1'b1,
            make_result(32'd0, 0, 0, 0, 0, 1, 0, 0, 1'b0, 1'b1));
    // year 100 from a non-decimal units nibble
    add_row(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h9A), 1'b1,
            make_result(32'd0, 0, 0, 0, 1, 1, 0, 100, 1'b0, 1'b1));
    add_row(make_snap(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h06, 8'h00), 1'b0, '0); // 12 AM
    add_row(make_snap(8'h00, 8'h00, 8'hB2, 8'h01, 8'h01, 8'h06, 8'h00), 1'b0, '0); // 12 PM
    add_row(make_snap(8'h00, 8'h00, 8'h81, 8'h01, 8'h01, 8'h06, 8'h00), 1'b0, '0); // 1 AM
    add_row(make_snap(8'h59, 8'h59, 8'hB1, 8'h15, 8'h07, 8'h02, 8'h37), 1'b0, '0); // 11 PM
    add_row(make_snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h04, 8'h99), 1'b0, '0); // last sane
    add_row(make_snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h04), 1'b0, '0); // leap day
    add_row(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h04), 1'b0, '0);
    add_row(make_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h04, 8'h01), 1'b0, '0); // non-leap
    add_row(make_snap(8'h00, 8'h00, 8'h00, 8'h30, 8'h09, 8'h05, 8'h00), 1'b0, '0); // year 0 leap
    add_row(make_snap(8'hB0, 8'h12, 8'h08, 8'h10, 8'h10, 8'h03, 8'h21), 1'b0, '0); // halted
    // non-decimal nibbles decode by formula, no error
    add_row(make_snap(8'h0F, 8'h7A, 8'h3F, 8'h3F, 8'h0A, 8'h01, 8'h0F), 1'b0, '0);
    // spare bits set on an otherwise sane snapshot
    add_row(make_snap(8'h30, 8'hB0, 8'h52, 8'hD5, 8'hE6, 8'hFB, 8'h23), 1'b0, '0);
    // 12-hour AM with spare bit 6 and hour 25
    add_row(make_snap(8'h00, 8'h00, 8'hDF, 8'h01, 8'h01, 8'h00, 8'h50), 1'b0, '0);
    // every time field at its widest, latest year
    add_row(make_snap(8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h12, 8'h07, 8'h99), 1'b0, '0);
  end

  // --------------------------------------------------------------------------
  // Expected results and checking
  // --------------------------------------------------------------------------

  rtc_out_t expected_results[$];
  rtc_out_t oldest_expected;
  int       mismatch_count = 0;
  int       cycle_count    = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // done_o and res_o are sampled at the edge that ends their cycle, before
  // the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, unix_seconds", res_o.unix_seconds, 32'd0);
      end else begin
        oldest_expected = expected_results.pop_front();
        if (res_o.unix_seconds !== oldest_expected.unix_seconds)
          report_mismatch("unix_seconds", res_o.unix_seconds, oldest_expected.unix_seconds);
        if (res_o.second_out !== oldest_expected.second_out)
          report_mismatch("second_out", 32'(res_o.second_out), 32'(oldest_expected.second_out));
        if (res_o.minute_out !== oldest_expected.minute_out)
          report_mismatch("minute_out", 32'(res_o.minute_out), 32'(oldest_expected.minute_out));
        if (res_o.hour_out !== oldest_expected.hour_out)
          report_mismatch("hour_out", 32'(res_o.hour_out), 32'(oldest_expected.hour_out));
        if (res_o.day_out !== oldest_expected.day_out)
          report_mismatch("day_out", 32'(res_o.day_out), 32'(oldest_expected.day_out));
        if (res_o.month_out !== oldest_expected.month_out)
          report_mismatch("month_out", 32'(res_o.month_out), 32'(oldest_expected.month_out));
        if (res_o.weekday_out !== oldest_expected.weekday_out)
          report_mismatch("weekday_out", 32'(res_o.weekday_out),
                          32'(oldest_expected.weekday_out));
        if (res_o.year_out !== oldest_expected.year_out)
          report_mismatch("year_out", 32'(res_o.year_out), 32'(oldest_expected.year_out));
        if (res_o.clock_halted !== oldest_expected.clock_halted)
          report_mismatch("clock_halted", 32'(res_o.clock_halted),
                          32'(oldest_expected.clock_halted));
        if (res_o.range_error !== oldest_expected.range_error)
          report_mismatch("range_error", 32'(res_o.range_error),
                          32'(oldest_expected.range_error));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("rtc_bcd_registers_to_unix_time_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------

  logic idle_enabled;

  // Optional idle burst, then hold the snapshot until the transfer edge.
  // start_i stays high between back-to-back items, so it is never lowered
  // and raised in the same step.
  task automatic send_snapshot(input rtc_in_t snap, input rtc_out_t expected);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      req_i   <= 56'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= snap;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_results.push_back(expected);
  endtask

  initial begin
    rtc_in_t snap;
    int      n;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    idle_enabled = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_snapshot(directed_rows[i].snap,
                    directed_rows[i].has_fixed ? directed_rows[i].fixed_res
                                               : predict_conversion(directed_rows[i].snap));
    end

    for (n = 0; n < RandomItems; n++) begin
      // quiet stretches now and then; none at all in the tail
      if (n % 64 == 0) idle_enabled = ($urandom_range(0, 2) != 0);
      if (n >= RandomItems - QuietTail) idle_enabled = 1'b0;
      snap = random_snapshot();
      send_snapshot(snap, predict_conversion(snap));
    end
    start_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("rtc_bcd_registers_to_unix_time_tb: PASS");
    end else begin
      $display("rtc_bcd_registers_to_unix_time_tb: FAIL");
    end
    $finish;
  end

endmodule
